// File: hw/rtl/stsd_pkg.sv
// Package for the step/direction generator: transfer payload structs,
// operation and register index codes, and fixed constants. No dependencies.
`timescale 1ns / 1ps

package stsd_pkg;

  typedef enum logic [2:0] {
    OP_STEP     = 3'd0,
    OP_MOMENTUM = 3'd1,
    OP_NORMAL   = 3'd2,
    OP_MANUAL   = 3'd3,
    OP_RESET    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_DIR_POLARITY  = 2'd0,
    CFG_TRAVEL_EXTENT = 2'd1
  } cfg_idx_e;

  localparam logic [31:0] MANUAL_STEPS  = 32'hFFFF_FFFF;
  localparam logic [6:0]  MOMENTUM_FULL = 7'd100;
  localparam logic [15:0] HALF_FRACTION = 16'd32768;
  localparam logic [15:0] EXTENT_RESET  = 16'd8000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] target_fraction;
  } in_item_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic               enable_n;
    logic signed [31:0] position_now;
    logic [31:0]        steps_left;
    logic [6:0]         momentum_pct;
  } out_item_t;

  typedef struct packed {
    logic        dir_polarity;
    logic [15:0] travel_extent;
  } cfg_t;

  // Input stage contents: item plus registered target product
  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] target_fraction;
    logic [31:0] product;
  } stage_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [6:0]         momentum;
  } axis_status_t;

endpackage

// File: hw/rtl/stsd_cfg_regs.sv
// Configuration registers: direction polarity and travel extent.
// Depends on stsd_pkg.
`timescale 1ns / 1ps

module stsd_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output stsd_pkg::cfg_t        cfg_o
);

  stsd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (stsd_pkg::cfg_idx_e'(cfg_index_i))
        stsd_pkg::CFG_DIR_POLARITY:  cfg_d.dir_polarity  = cfg_data_i[0];
        stsd_pkg::CFG_TRAVEL_EXTENT: cfg_d.travel_extent = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_polarity  <= 1'b1;
      cfg_q.travel_extent <= stsd_pkg::EXTENT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hw/rtl/stsd_in_stage.sv
// Input register stage: captures an item and the target product t * extent.
// Depends on stsd_pkg.
`timescale 1ns / 1ps

module stsd_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  stsd_pkg::in_item_t    in_data_i,
  input  logic [15:0]           travel_extent_i,
  input  logic                  take_i,
  output logic                  stage_valid_o,
  output stsd_pkg::stage_t      stage_o
);

  logic             valid_q, valid_d;
  stsd_pkg::stage_t stage_q, stage_d;
  logic             load;

  assign in_ready_o    = !valid_q || take_i;
  assign load          = in_valid_i && in_ready_o;
  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
    stage_d.operation       = in_data_i.operation;
    stage_d.target_fraction = in_data_i.target_fraction;
    stage_d.product         = 32'(in_data_i.target_fraction) * 32'(travel_extent_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stage_q <= stage_d;
    end
  end

endmodule

// File: hw/rtl/stsd_axis.sv
// Axis state, per-operation update logic and result register.
// Depends on stsd_pkg.
`timescale 1ns / 1ps

module stsd_axis (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  stsd_pkg::cfg_t          cfg_i,
  input  logic                    stage_valid_i,
  input  stsd_pkg::stage_t        stage_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output stsd_pkg::out_item_t     out_data_o,
  output stsd_pkg::axis_status_t  status_o
);

  logic [31:0]        rem_q, rem_d;
  logic signed [31:0] pos_q, pos_d;
  logic               dir_q, dir_d;
  logic               phase_q, phase_d;
  logic [6:0]         mom_q, mom_d;
  logic               pin_step_q, pin_step_d;
  logic               pin_dir_q, pin_dir_d;
  logic               pin_en_n_q, pin_en_n_d;
  logic               out_valid_q;
  stsd_pkg::out_item_t out_q;

  logic               load;
  logic signed [48:0] num;
  logic [48:0]        mag;
  logic               set_dir;
  logic               new_dir;

  assign take_o      = !out_valid_q || out_ready_i;
  assign load        = stage_valid_i && take_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.position = pos_q;
  assign status_o.momentum = mom_q;

  // Distance to target, scaled by 2^16
  assign num = $signed({17'd0, stage_i.product}) - $signed({pos_q[31], pos_q, 16'd0});
  assign mag = num[48] ? 49'(-num) : 49'(num);

  always_comb begin
    rem_d      = rem_q;
    pos_d      = pos_q;
    dir_d      = dir_q;
    phase_d    = phase_q;
    mom_d      = mom_q;
    pin_step_d = pin_step_q;
    pin_dir_d  = pin_dir_q;
    pin_en_n_d = pin_en_n_q;
    set_dir    = 1'b0;
    new_dir    = dir_q;
    case (stsd_pkg::op_e'(stage_i.operation))
      stsd_pkg::OP_STEP: begin
        if (rem_q != 32'd0) begin
          pin_en_n_d = 1'b0;
          if (phase_q) begin
            rem_d = rem_q - 32'd1;
            if (dir_q) begin
              if (pos_q != stsd_pkg::POS_MAX) pos_d = pos_q + 32'sd1;
            end else begin
              if (pos_q != stsd_pkg::POS_MIN) pos_d = pos_q - 32'sd1;
            end
          end
          pin_step_d = phase_q;
          pin_dir_d  = cfg_i.dir_polarity ? dir_q : !dir_q;
          phase_d    = !phase_q;
        end else begin
          pin_en_n_d = 1'b1;
        end
      end
      stsd_pkg::OP_MOMENTUM: begin
        if (mom_q < stsd_pkg::MOMENTUM_FULL) mom_d = mom_q + 7'd1;
      end
      stsd_pkg::OP_NORMAL: begin
        rem_d   = mag[47:16];
        set_dir = 1'b1;
        new_dir = !num[48] && (num != 49'sd0);
      end
      stsd_pkg::OP_MANUAL: begin
        rem_d   = stsd_pkg::MANUAL_STEPS;
        set_dir = 1'b1;
        new_dir = stage_i.target_fraction > stsd_pkg::HALF_FRACTION;
      end
      stsd_pkg::OP_RESET: begin
        rem_d = 32'd0;
        mom_d = 7'd0;
      end
      default: ;
    endcase
    if (set_dir) begin
      if (new_dir != dir_q) mom_d = 7'd0;
      dir_d = new_dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= 32'd0;
      pos_q       <= 32'sd0;
      dir_q       <= 1'b0;
      phase_q     <= 1'b0;
      mom_q       <= 7'd0;
      pin_step_q  <= 1'b0;
      pin_dir_q   <= 1'b0;
      pin_en_n_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        rem_q      <= rem_d;
        pos_q      <= pos_d;
        dir_q      <= dir_d;
        phase_q    <= phase_d;
        mom_q      <= mom_d;
        pin_step_q <= pin_step_d;
        pin_dir_q  <= pin_dir_d;
        pin_en_n_q <= pin_en_n_d;
      end
      if (take_o) begin
        out_valid_q <= stage_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.step_level   <= pin_step_d;
      out_q.dir_level    <= pin_dir_d;
      out_q.enable_n     <= pin_en_n_d;
      out_q.position_now <= pos_d;
      out_q.steps_left   <= rem_d;
      out_q.momentum_pct <= mom_d;
    end
  end

endmodule

// File: hw/rtl/stepper_step_dir_generator_unit.sv
// Top level of the single-axis step/direction generator.
// Depends on stsd_pkg, stsd_cfg_regs, stsd_in_stage and stsd_axis.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid_i/in_ready_o/in_data_i) carries one operation per
//   transfer: step tick, momentum tick, normal move, manual move or reset.
// - Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result per input item: pin levels, position, steps left and momentum.
// - Config channel (cfg_valid_i/cfg_ready_o) writes direction polarity
//   (index 0) and travel extent (index 1); always ready. Write only when idle.
// - Path: input register (holding the target product), then the axis update
//   into the result register, which loads only while it is free or being read.
// - Throughput: one item per cycle unless the receiver stalls; each update
//   is registered before the next item, so back-to-back items see its effects.
// - When the receiver stalls, the result register holds and the input register
//   still takes one more item; in_ready_o drops only when both are full.
// - Reset clears position, steps, direction, phase and momentum, sets enable_n
//   high, polarity to 1 and extent to 8000. No clearing pass is needed.
module stepper_step_dir_generator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stsd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stsd_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  stsd_pkg::cfg_t          cfg;
  stsd_pkg::stage_t        stage;
  stsd_pkg::axis_status_t  status;
  logic                    stage_valid;
  logic                    take;

  stsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  stsd_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .travel_extent_i (cfg.travel_extent),
    .take_i          (take),
    .stage_valid_o   (stage_valid),
    .stage_o         (stage)
  );

  stsd_axis u_axis (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .status_o      (status)
  );

  a_mom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.momentum <= stsd_pkg::MOMENTUM_FULL)
    else $error("momentum above full scale");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (status.position == $past(status.position) ||
         status.position == $past(status.position) + 32'sd1 ||
         status.position == $past(status.position) - 32'sd1))
    else $error("position moved by more than one step");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && stage_valid))
    else $error("input blocked without a full pipeline");

endmodule
